### rtl/core/rgba_box_downsample_2x2_macros.svh
// assertion macros used by the checker file rbd_checker.sv
`ifndef RGBA_BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define RGBA_BOX_DOWNSAMPLE_2X2_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RBD_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define RBD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// condition that must hold in the cycle after a reset edge
`define RBD_ASSERT_AFTER_RESET(label, clk, rst_n, post, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (post)) \
    else $error(msg);

`endif

### rtl/core/rbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared constants and types of the rgba 2x2 box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int X_W        = $clog2(LINE_DEPTH);
  localparam int CFG_W_BITS = 13;
  localparam int CFG_H_BITS = 16;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_CH     = 4;
  localparam int CH_W       = 8;
  localparam int PAIR_W     = CH_W + 1;
  localparam int QUAD_W     = CH_W + 2;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IMG_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_IMG_HEIGHT = 1'b1;

  typedef logic [NUM_CH-1:0][CH_W-1:0]   pixel_t;
  typedef logic [NUM_CH-1:0][PAIR_W-1:0] pair_t;

  typedef struct packed {
    logic           we;
    logic           re;
    logic [X_W-1:0] addr;
    pair_t          wdata;
  } line_req_t;

  typedef struct packed {
    logic  valid;
    logic  use_line;
    logic  row_end;
    logic  image_end;
    pair_t pair;
  } item_t;

endpackage
`default_nettype wire

### rtl/core/rbd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_in_if
// Source pixel channel: valid/ready handshake with one rgba8 pixel.
// ----------------------------------------------------------------------------
interface rbd_in_if;
  logic                 valid;
  logic                 ready;
  logic [rbd_pkg::CH_W-1:0] red_in;
  logic [rbd_pkg::CH_W-1:0] green_in;
  logic [rbd_pkg::CH_W-1:0] blue_in;
  logic [rbd_pkg::CH_W-1:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

// ----------------------------------------------------------------------------
// rbd_out_if
// Downsampled pixel channel with row and image end markers.
// ----------------------------------------------------------------------------
interface rbd_out_if;
  logic                 valid;
  logic                 ready;
  logic [rbd_pkg::CH_W-1:0] red_out;
  logic [rbd_pkg::CH_W-1:0] green_out;
  logic [rbd_pkg::CH_W-1:0] blue_out;
  logic [rbd_pkg::CH_W-1:0] alpha_out;
  logic                 row_end;
  logic                 image_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, output row_end, output image_end, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, input row_end, input image_end, output ready);
endinterface
`default_nettype wire

### rtl/core/rbd_scan_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_scan_ctrl
// Configuration registers, raster counters, horizontal pair sum and the
// decode of what each accepted pixel does to the line store and the output.
// ----------------------------------------------------------------------------
module rbd_scan_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire rbd_pkg::cfg_idx_t              cfg_index,
  input  wire logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire rbd_pkg::pixel_t                px,
  output rbd_pkg::item_t                      item,
  output rbd_pkg::line_req_t                  line_req
);

  localparam int WB = rbd_pkg::CFG_W_BITS;
  localparam int HB = rbd_pkg::CFG_H_BITS;
  localparam int CW = rbd_pkg::COL_W;
  localparam int XW = rbd_pkg::X_W;

  logic [WB-1:0]   src_w_r;
  logic [HB-1:0]   src_h_r;
  logic [CW-1:0]   col_r, col_nxt;
  logic [HB-1:0]   row_r, row_nxt;
  rbd_pkg::pixel_t acc_r;

  logic [WB-1:0]   w_eff, w_m1;
  logic [WB-2:0]   w_half, dw_m1;
  logic [HB-1:0]   h_eff, h_m1;
  logic [HB-2:0]   h_half, dh_m1, y, y_eff;
  logic [XW-1:0]   x;
  logic            w_one, h_one, pair_done, in_rows, emit, store, accept;
  rbd_pkg::pair_t  pair;

  always_comb begin
    w_eff = src_w_r;
    if (src_w_r == '0) begin
      w_eff = WB'(1);
    end else if (src_w_r > WB'(rbd_pkg::MAX_WIDTH)) begin
      w_eff = WB'(rbd_pkg::MAX_WIDTH);
    end
    h_eff  = (src_h_r == '0) ? HB'(1) : src_h_r;
    w_m1   = w_eff - WB'(1);
    h_m1   = h_eff - HB'(1);
    w_half = w_eff[WB-1:1];
    h_half = h_eff[HB-1:1];
    dw_m1  = (w_half == '0) ? '0 : w_half - (WB-1)'(1);
    dh_m1  = (h_half == '0) ? '0 : h_half - (HB-1)'(1);
    w_one  = (w_eff == WB'(1));
    h_one  = (h_eff == HB'(1));
  end

  always_comb begin
    x = col_r[CW-1:1];
    y = row_r[HB-1:1];
    if (w_one) begin
      pair_done = (col_r == '0);
    end else begin
      pair_done = col_r[0] && ({1'b0, x} < w_half);
    end
    for (int k = 0; k < rbd_pkg::NUM_CH; k++) begin
      if (w_one) begin
        pair[k] = {px[k], 1'b0};
      end else begin
        pair[k] = {1'b0, acc_r[k]} + {1'b0, px[k]};
      end
    end
    in_rows = (y < h_half);
    // a single-row image doubles its row, so every pair emits
    if (h_one) begin
      emit  = pair_done && (row_r == '0);
      store = 1'b0;
      y_eff = '0;
    end else begin
      emit  = pair_done && in_rows && row_r[0];
      store = pair_done && in_rows && !row_r[0];
      y_eff = y;
    end
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    item.valid     = accept && emit;
    item.use_line  = !h_one;
    item.row_end   = ({1'b0, x} == dw_m1);
    item.image_end = ({1'b0, x} == dw_m1) && (y_eff == dh_m1);
    item.pair      = pair;

    line_req.we    = accept && store;
    line_req.re    = accept && emit && !h_one;
    line_req.addr  = x;
    line_req.wdata = pair;
  end

  // wrap on or beyond the last position
  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if ({1'b0, col_r} >= w_m1) begin
      col_nxt = '0;
      row_nxt = (row_r >= h_m1) ? '0 : row_r + HB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= WB'(1);
      src_h_r <= HB'(1);
      col_r   <= '0;
      row_r   <= '0;
      acc_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rbd_pkg::CFG_IMG_WIDTH:  src_w_r <= cfg_data[WB-1:0];
          rbd_pkg::CFG_IMG_HEIGHT: src_h_r <= cfg_data[HB-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        if (!w_one && !col_r[0]) begin
          acc_r <= px;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/rbd_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_line_store
// Holds the pair sums of the even source row, one entry per output column,
// with a registered read port.
// ----------------------------------------------------------------------------
module rbd_line_store (
  input  wire logic               clk,
  input  wire rbd_pkg::line_req_t req,
  output rbd_pkg::pair_t          rd_data_r
);

  rbd_pkg::pair_t mem [rbd_pkg::LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/rbd_combine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_combine
// Holds an emitting pixel while its line entry is read, adds the two pair
// sums, divides by four and drives the output register.
// ----------------------------------------------------------------------------
module rbd_combine (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rbd_pkg::item_t item,
  input  wire rbd_pkg::pair_t line_rd,
  output logic                in_ready,
  rbd_out_if.source           out_pix
);

  localparam int QW = rbd_pkg::QUAD_W;

  logic            s1_valid_r;
  rbd_pkg::item_t  s1_item_r;
  logic            out_valid_r;
  rbd_pkg::pixel_t out_px_r, out_px_nxt;
  logic            out_row_end_r, out_image_end_r;
  logic            out_free, s1_free;
  logic [QW-1:0]   quad;

  assign out_free = !out_valid_r || out_pix.ready;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_ready = s1_free;

  always_comb begin
    quad = '0;
    for (int k = 0; k < rbd_pkg::NUM_CH; k++) begin
      if (s1_item_r.use_line) begin
        quad = {1'b0, line_rd[k]} + {1'b0, s1_item_r.pair[k]};
      end else begin
        quad = {s1_item_r.pair[k], 1'b0};
      end
      out_px_nxt[k] = quad[QW-1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= item.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && item.valid) begin
      s1_item_r <= item;
    end
    if (out_free && s1_valid_r) begin
      out_px_r        <= out_px_nxt;
      out_row_end_r   <= s1_item_r.row_end;
      out_image_end_r <= s1_item_r.image_end;
    end
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.red_out   = out_px_r[0];
  assign out_pix.green_out = out_px_r[1];
  assign out_pix.blue_out  = out_px_r[2];
  assign out_pix.alpha_out = out_px_r[3];
  assign out_pix.row_end   = out_row_end_r;
  assign out_pix.image_end = out_image_end_r;

endmodule
`default_nettype wire

### rtl/core/rgba_box_downsample_2x2.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2
// Halves an rgba8 image with a 2x2 box filter (truncated average).
// ----------------------------------------------------------------------------
// Usage:
//  - write the image width (index 0) and image height (index 1) on the cfg
//    port while no pixel is in flight; both come out of reset as 1
//  - in_pix takes source pixels in raster order, one transaction per clock
//    while ready is high; out_pix gives max(1,min(w,4096)/2) x max(1,h/2) pixels,
//    row_end on the last pixel of each output row, image_end on the last pixel
//    of the image; throughput is one source pixel per clock unless ready drops;
//    the single-port line store takes at most one write or one read per pixel
//  - the pixel that closes a 2x2 block passes through the hold stage (with the
//    line read) and then the output register on its way to out_pix.valid
//  - when out_pix stalls, one more result is held in the hold stage and
//    in_pix keeps accepting pixels that produce no result; ready drops only
//    when both stages are full
//  - synchronous reset clears the counters and empties the pipeline; the
//    line store needs no clearing since even rows always fill it first
// ----------------------------------------------------------------------------
module rgba_box_downsample_2x2 (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire rbd_pkg::cfg_idx_t              cfg_index,
  input  wire logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
  rbd_in_if.sink                              in_pix,
  rbd_out_if.source                           out_pix
);

  rbd_pkg::pixel_t    px;
  rbd_pkg::item_t     item;
  rbd_pkg::line_req_t line_req;
  rbd_pkg::pair_t     line_rd;
  logic               in_ready;

  assign px = {in_pix.alpha_in, in_pix.blue_in, in_pix.green_in, in_pix.red_in};
  assign in_pix.ready = in_ready;

  rbd_scan_ctrl u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_pix.valid),
    .in_ready  (in_ready),
    .px        (px),
    .item      (item),
    .line_req  (line_req)
  );

  rbd_line_store u_line (
    .clk       (clk),
    .req       (line_req),
    .rd_data_r (line_rd)
  );

  rbd_combine u_comb (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .line_rd  (line_rd),
    .in_ready (in_ready),
    .out_pix  (out_pix)
  );

endmodule
`default_nettype wire

### rtl/core/rbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks of the downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgba_box_downsample_2x2_macros.svh"

module rbd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_row_end,
  input wire logic out_image_end
);

  // a stalled result transaction stays offered
  `RBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out dropped")

  // the last pixel of the image also closes its row
  `RBD_ASSERT_SAME(a_image_row, clk, rst_n, out_valid && out_image_end, out_row_end, "image_end")

  // with the output register empty the input is never blocked
  `RBD_ASSERT_SAME(a_ready_empty, clk, rst_n, !out_valid, in_ready, "in_ready low")

  `RBD_ASSERT_AFTER_RESET(a_reset_empty, clk, rst_n, !out_valid, "valid after reset")

endmodule

bind rgba_box_downsample_2x2 rbd_checker u_rbd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_pix.ready),
  .out_valid     (out_pix.valid),
  .out_ready     (out_pix.ready),
  .out_row_end   (out_pix.row_end),
  .out_image_end (out_pix.image_end)
);
`default_nettype wire
